// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared codes, types and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // parse modes
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_STR    = 3'd1;
    localparam logic [2:0] MODE_ESC    = 3'd2;
    localparam logic [2:0] MODE_HEX1   = 3'd3;
    localparam logic [2:0] MODE_LOW_BS = 3'd4;
    localparam logic [2:0] MODE_LOW_U  = 3'd5;
    localparam logic [2:0] MODE_HEX2   = 3'd6;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
    localparam logic [2:0] ERR_CONTROL  = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_HEX      = 3'd4;
    localparam logic [2:0] ERR_LOW_ESC  = 3'd5;
    localparam logic [2:0] ERR_LOW_SURR = 3'd6;
    localparam logic [2:0] ERR_CODE_PT  = 3'd7;

    // characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_U     = 8'h75;

    // surrogate prefixes (top six bits of a 16-bit unit)
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    // number of result beats one input byte can produce
    localparam int MAX_RES = 4;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    // one result beat
    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       done;
        logic [2:0] err;
    } res_t;

    // hex digit decode: bit 4 set when the byte is a digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Takes a quoted JSON string one byte per beat and gives the decoded text as
// UTF-8 bytes, with a done beat on the closing quote or a coded error beat.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  input   | in_valid, in_ready, in_byte               | in
//  result  | out_valid, out_ready, out_byte,           | out
//          | byte_valid, last_of_run, string_done,     |
//          | error_code                                |
//
// Each input byte is decoded in the cycle it is taken; its 0 to 4 result beats
// go into a small result buffer and leave one per cycle while out_ready is high.
// A byte is taken every cycle while each gives at most one result and out_ready
// is high; a byte with several results holds the input until the last of them
// is being taken at the result port.
// Reset puts the parser in idle, waiting for the opening quote, with the
// result buffer empty. A stalled result port holds the input once the
// buffer's last beat is not being taken.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       last_of_run,
    output logic       string_done,
    output logic [2:0] error_code
);

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;

    res_t                 buf_reg [MAX_RES];
    logic [RES_CNT_W-1:0] rem_reg;

    res_t                 res_next [MAX_RES];
    logic [RES_CNT_W-1:0] n_res;

    logic        in_acc;
    logic        out_acc;
    logic [4:0]  hd;
    logic [15:0] hv;
    logic [20:0] cp;
    logic        emit_cp;
    logic [7:0]  single;
    logic        emit_single;
    logic [2:0]  err;
    logic        done;

    // handshake
    assign out_valid = (rem_reg != '0);
    assign out_acc   = out_valid && out_ready;
    assign in_ready  = (rem_reg == '0)
                    || ((rem_reg == RES_CNT_W'(1)) && out_ready);
    assign in_acc    = in_valid && in_ready;

    assign hd = hex_digit(in_byte);
    assign hv = {acc_reg[11:0], hd[3:0]};

    // parser step
    always_comb
    begin
        mode_next   = mode_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        hs_next     = hs_reg;
        err         = ERR_NONE;
        done        = 1'b0;
        emit_single = 1'b0;
        single      = in_byte;
        emit_cp     = 1'b0;
        cp          = {5'd0, hv};
        unique case (mode_reg)
            MODE_STR:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    done      = 1'b1;
                    mode_next = MODE_IDLE;
                end
                else if (in_byte < 8'h20)
                begin
                    err = ERR_CONTROL;
                end
                else if (in_byte == CH_BSL)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    emit_single = 1'b1;
                end
            end
            MODE_ESC:
            begin
                mode_next   = MODE_STR;
                emit_single = 1'b1;
                case (in_byte)
                    CH_QUOTE, CH_BSL, CH_SLASH: single = in_byte;
                    8'h62: single = 8'h08;
                    8'h66: single = 8'h0c;
                    8'h6e: single = 8'h0a;
                    8'h72: single = 8'h0d;
                    8'h74: single = 8'h09;
                    CH_U:
                    begin
                        emit_single = 1'b0;
                        mode_next   = MODE_HEX1;
                        cnt_next    = 2'd0;
                        acc_next    = 16'd0;
                    end
                    default:
                    begin
                        emit_single = 1'b0;
                        err         = ERR_ESCAPE;
                    end
                endcase
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (!hd[4])
                begin
                    err = ERR_HEX;
                end
                else if (cnt_reg != 2'd3)
                begin
                    acc_next = hv;
                    cnt_next = cnt_reg + 2'd1;
                end
                else
                begin
                    cnt_next = 2'd0;
                    acc_next = 16'd0;
                    if (mode_reg == MODE_HEX1)
                    begin
                        if (hv[15:10] == SURR_HIGH)
                        begin
                            hs_next   = hv[9:0];
                            mode_next = MODE_LOW_BS;
                        end
                        else if (hv == 16'd0 || hv[15:10] == SURR_LOW)
                        begin
                            err = ERR_CODE_PT;
                        end
                        else
                        begin
                            emit_cp = 1'b1;
                        end
                    end
                    else if (hv[15:10] != SURR_LOW)
                    begin
                        err = ERR_LOW_SURR;
                    end
                    else
                    begin
                        // 0x10000 + (high << 10) + low offset
                        cp      = {({1'b0, hs_reg} + 11'd64), hv[9:0]};
                        hs_next = 10'd0;
                        emit_cp = 1'b1;
                    end
                    if (emit_cp)
                    begin
                        mode_next = MODE_STR;
                    end
                end
            end
            MODE_LOW_BS:
            begin
                if (in_byte != CH_BSL)
                begin
                    err = ERR_LOW_ESC;
                end
                else
                begin
                    mode_next = MODE_LOW_U;
                end
            end
            MODE_LOW_U:
            begin
                if (in_byte != CH_U)
                begin
                    err = ERR_LOW_ESC;
                end
                else
                begin
                    mode_next = MODE_HEX2;
                    cnt_next  = 2'd0;
                    acc_next  = 16'd0;
                end
            end
            default:
            begin
                if (in_byte != CH_QUOTE)
                begin
                    err = ERR_NO_QUOTE;
                end
                else
                begin
                    mode_next = MODE_STR;
                    cnt_next  = 2'd0;
                    acc_next  = 16'd0;
                    hs_next   = 10'd0;
                end
            end
        endcase
        if (err != ERR_NONE)
        begin
            mode_next = MODE_IDLE;
            cnt_next  = 2'd0;
            acc_next  = 16'd0;
            hs_next   = 10'd0;
        end
    end

    // result beats for this byte
    always_comb
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            res_next[i] = '{data: 8'd0, bvalid: 1'b0, done: 1'b0, err: ERR_NONE};
        end
        n_res = '0;
        if (err != ERR_NONE)
        begin
            res_next[0].err = err;
            n_res           = RES_CNT_W'(1);
        end
        else if (done)
        begin
            res_next[0].done = 1'b1;
            n_res            = RES_CNT_W'(1);
        end
        else if (emit_single)
        begin
            res_next[0].data   = single;
            res_next[0].bvalid = 1'b1;
            n_res              = RES_CNT_W'(1);
        end
        else if (emit_cp)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                res_next[i].bvalid = 1'b1;
            end
            if (cp[20:7] == 14'd0)
            begin
                res_next[0].data = {1'b0, cp[6:0]};
                n_res            = RES_CNT_W'(1);
            end
            else if (cp[20:11] == 10'd0)
            begin
                res_next[0].data = {3'b110, cp[10:6]};
                res_next[1].data = {2'b10, cp[5:0]};
                n_res            = RES_CNT_W'(2);
            end
            else if (cp[20:16] == 5'd0)
            begin
                res_next[0].data = {4'b1110, cp[15:12]};
                res_next[1].data = {2'b10, cp[11:6]};
                res_next[2].data = {2'b10, cp[5:0]};
                n_res            = RES_CNT_W'(3);
            end
            else
            begin
                res_next[0].data = {5'b11110, cp[20:18]};
                res_next[1].data = {2'b10, cp[17:12]};
                res_next[2].data = {2'b10, cp[11:6]};
                res_next[3].data = {2'b10, cp[5:0]};
                n_res            = RES_CNT_W'(4);
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= 2'd0;
            acc_reg  <= 16'd0;
            hs_reg   <= 10'd0;
        end
        else if (in_acc)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            hs_reg   <= hs_next;
        end
    end

    // result buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (in_acc)
        begin
            rem_reg <= n_res;
        end
        else if (out_acc)
        begin
            rem_reg <= rem_reg - RES_CNT_W'(1);
        end
    end

    // result buffer payload, shifts down one beat per take
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < MAX_RES; i++)
            begin
                buf_reg[i] <= res_next[i];
            end
        end
        else if (out_acc)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    // output beat
    assign out_byte    = buf_reg[0].data;
    assign byte_valid  = buf_reg[0].bvalid;
    assign string_done = buf_reg[0].done;
    assign error_code  = buf_reg[0].err;
    assign last_of_run = (rem_reg == RES_CNT_W'(1));

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON string unescaper. A scoreboard decodes
// every accepted input byte and queues the UTF-8, done and error beats it
// should cause. Each result beat is compared field by field with the oldest
// queued beat. Stimulus is a short directed string followed by random quoted
// strings with random content, broken escapes and noise bytes. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import jsu_pkg::*;

    // character codes used by stimulus and prediction
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6e;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CTL_BS     = 8'h08;
    localparam logic [7:0] CTL_FF     = 8'h0c;
    localparam logic [7:0] CTL_LF     = 8'h0a;
    localparam logic [7:0] CTL_CR     = 8'h0d;
    localparam logic [7:0] CTL_TAB    = 8'h09;

    localparam int ITEM_TARGET = 350;
    localparam int IDLE_LIMIT  = 4000;
    localparam int END_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       last;
        logic       done;
        logic [2:0] err;
    } out_beat_t;

    // decodes accepted bytes into expected beats and checks result beats
    class unescape_scoreboard;
        out_beat_t   beat_q[$];
        int          errors;
        logic [2:0]  mode;
        logic [1:0]  ndig;
        logic [15:0] acc;
        logic [9:0]  hi_part;

        function new();
            errors  = 0;
            mode    = MODE_IDLE;
            ndig    = 2'd0;
            acc     = 16'd0;
            hi_part = 10'd0;
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        function void add_beat(logic [7:0] d, logic bv, logic lst, logic dn, logic [2:0] e);
            out_beat_t t;
            t.data   = d;
            t.bvalid = bv;
            t.last   = lst;
            t.done   = dn;
            t.err    = e;
            beat_q.push_back(t);
        endfunction

        // error beat, parser back to idle
        function void abort_with(logic [2:0] e);
            add_beat(8'h00, 1'b0, 1'b1, 1'b0, e);
            mode    = MODE_IDLE;
            ndig    = 2'd0;
            acc     = 16'd0;
            hi_part = 10'd0;
        endfunction

        // utf-8 encoding of one code point
        function void put_code_point(logic [20:0] cp);
            if (cp <= 21'h7f)
            begin
                add_beat(cp[7:0], 1'b1, 1'b1, 1'b0, ERR_NONE);
            end
            else if (cp <= 21'h7ff)
            begin
                add_beat({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                add_beat({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end
            else if (cp <= 21'hffff)
            begin
                add_beat({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                add_beat({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                add_beat({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end
            else
            begin
                add_beat({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                add_beat({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                add_beat({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                add_beat({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end
            mode = MODE_STR;
            ndig = 2'd0;
            acc  = 16'd0;
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9)
                return int'(c - CH_0);
            if (c >= CH_LOWER_A && c <= CH_LOWER_F)
                return int'(c - CH_LOWER_A) + 10;
            if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                return int'(c - CH_UPPER_A) + 10;
            return -1;
        endfunction

        // one accepted input beat
        function void note_byte(logic [7:0] c);
            int          d;
            logic [3:0]  nib;
            logic [15:0] v;
            case (mode)
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_beat(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                        mode = MODE_IDLE;
                    end
                    else if (c < CH_SPACE)
                        abort_with(ERR_CONTROL);
                    else if (c == CH_BSL)
                        mode = MODE_ESC;
                    else
                        add_beat(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                end
                MODE_ESC:
                begin
                    mode = MODE_STR;
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH: add_beat(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                        CH_B: add_beat(CTL_BS, 1'b1, 1'b1, 1'b0, ERR_NONE);
                        CH_F: add_beat(CTL_FF, 1'b1, 1'b1, 1'b0, ERR_NONE);
                        CH_N: add_beat(CTL_LF, 1'b1, 1'b1, 1'b0, ERR_NONE);
                        CH_R: add_beat(CTL_CR, 1'b1, 1'b1, 1'b0, ERR_NONE);
                        CH_T: add_beat(CTL_TAB, 1'b1, 1'b1, 1'b0, ERR_NONE);
                        CH_U:
                        begin
                            mode = MODE_HEX1;
                            ndig = 2'd0;
                            acc  = 16'd0;
                        end
                        default: abort_with(ERR_ESCAPE);
                    endcase
                end
                MODE_HEX1, MODE_HEX2:
                begin
                    d = hex_value(c);
                    if (d < 0)
                        abort_with(ERR_HEX);
                    else
                    begin
                        nib = d[3:0];
                        v = {acc[11:0], nib};
                        if (ndig < 2'd3)
                        begin
                            acc  = v;
                            ndig = ndig + 2'd1;
                        end
                        else
                        begin
                            ndig = 2'd0;
                            acc  = 16'd0;
                            if (mode == MODE_HEX1)
                            begin
                                if (v[15:10] == SURR_HIGH)
                                begin
                                    hi_part = v[9:0];
                                    mode    = MODE_LOW_BS;
                                end
                                else if (v == 16'd0 || v[15:10] == SURR_LOW)
                                    abort_with(ERR_CODE_PT);
                                else
                                    put_code_point({5'd0, v});
                            end
                            else if (v[15:10] != SURR_LOW)
                                abort_with(ERR_LOW_SURR);
                            else
                            begin
                                put_code_point(21'h10000 + {hi_part, v[9:0]});
                                hi_part = 10'd0;
                            end
                        end
                    end
                end
                MODE_LOW_BS:
                begin
                    if (c != CH_BSL)
                        abort_with(ERR_LOW_ESC);
                    else
                        mode = MODE_LOW_U;
                end
                MODE_LOW_U:
                begin
                    if (c != CH_U)
                        abort_with(ERR_LOW_ESC);
                    else
                    begin
                        mode = MODE_HEX2;
                        ndig = 2'd0;
                        acc  = 16'd0;
                    end
                end
                default:
                begin
                    if (c != CH_QUOTE)
                        abort_with(ERR_NO_QUOTE);
                    else
                    begin
                        mode    = MODE_STR;
                        ndig    = 2'd0;
                        acc     = 16'd0;
                        hi_part = 10'd0;
                    end
                end
            endcase
        endfunction

        // one accepted result beat against the oldest expectation
        task check_beat(logic [7:0] d, logic bv, logic lst, logic dn, logic [2:0] e);
            out_beat_t want;
            if (beat_q.size() == 0)
            begin
                report($sformatf("result beat %02h with nothing expected", d));
                return;
            end
            want = beat_q.pop_front();
            if (d !== want.data)
                report($sformatf("out_byte got %02h want %02h", d, want.data));
            if (bv !== want.bvalid)
                report($sformatf("byte_valid got %b want %b", bv, want.bvalid));
            if (lst !== want.last)
                report($sformatf("last_of_run got %b want %b", lst, want.last));
            if (dn !== want.done)
                report($sformatf("string_done got %b want %b", dn, want.done));
            if (e !== want.err)
                report($sformatf("error_code got %0d want %0d", e, want.err));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
    logic [2:0] error_code;

    unescape_scoreboard sb = new();
    int bytes_sent = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int next_tail = 0;
    bit quiet = 1'b0;

    json_string_unescape_utf8 u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .string_done (string_done),
        .error_code  (error_code)
    );

    always #5 clk = ~clk;

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit is_esc_letter(logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UPPER_A && c <= CH_UPPER_F)
            || (c >= CH_LOWER_A && c <= CH_LOWER_F);
    endfunction

    // hex digit with random letter case
    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return CH_0 + 8'(n);
        if ($urandom_range(0, 1))
            return CH_UPPER_A + 8'(n - 4'd10);
        return CH_LOWER_A + 8'(n - 4'd10);
    endfunction

    // result side: random stalls, check every accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_beat(out_byte, byte_valid, last_of_run, string_done, error_code);
                stall_left = quiet ? 0 : pick_gap();
            end
            else if (stall_left > 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 15) == 0)
                stall_left = pick_gap();
            out_ready <= (stall_left == 0);
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // one input beat, valid held until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // hold the input until all expected beats are out
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.beat_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_u(input logic [15:0] v);
        send_byte(CH_BSL);
        send_byte(CH_U);
        send_byte(hex_char(v[15:12]));
        send_byte(hex_char(v[11:8]));
        send_byte(hex_char(v[7:4]));
        send_byte(hex_char(v[3:0]));
    endtask

    function automatic logic [15:0] pick_high();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 16'hd800 : 16'hdbff;
        return 16'hd800 | 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] pick_low();
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 1) ? 16'hdc00 : 16'hdfff;
        return 16'hdc00 | 16'($urandom_range(0, 1023));
    endfunction

    // non-surrogate, non-zero code unit, often on an encoding boundary
    function automatic logic [15:0] pick_bmp();
        logic [15:0] v;
        case ($urandom_range(0, 15))
            0: v = 16'h0001;
            1: v = 16'h007f;
            2: v = 16'h0080;
            3: v = 16'h07ff;
            4: v = 16'h0800;
            5: v = 16'hd7ff;
            6: v = 16'he000;
            7: v = 16'hffff;
            8, 9: v = 16'($urandom_range(1, 16'h7f));
            10, 11: v = 16'($urandom_range(16'h80, 16'h7ff));
            default:
            begin
                do
                    v = 16'($urandom);
                while (v == 16'd0 || v[15:11] == 5'b11011);
            end
        endcase
        return v;
    endfunction

    // \u with p good digits and then a byte that is not hex
    task automatic send_bad_hex();
        int p;
        logic [7:0] b;
        p = $urandom_range(0, 3);
        send_byte(CH_BSL);
        send_byte(CH_U);
        repeat (p) send_byte(hex_char(4'($urandom_range(0, 15))));
        do
            b = 8'($urandom_range(0, 255));
        while (is_hex_char(b));
        send_byte(b);
    endtask

    // one piece of string content
    task automatic send_segment();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                do
                    b = 8'($urandom_range(CH_SPACE, 255));
                while (b == CH_QUOTE || b == CH_BSL);
                send_byte(b);
            end
            4, 5:
            begin
                send_byte(CH_BSL);
                case ($urandom_range(0, 7))
                    0: send_byte(CH_QUOTE);
                    1: send_byte(CH_BSL);
                    2: send_byte(CH_SLASH);
                    3: send_byte(CH_B);
                    4: send_byte(CH_F);
                    5: send_byte(CH_N);
                    6: send_byte(CH_R);
                    default: send_byte(CH_T);
                endcase
            end
            6, 7: send_u(pick_bmp());
            default:
            begin
                send_u(pick_high());
                send_u(pick_low());
            end
        endcase
    endtask

    // broken ending, kinds taken in turn so each one comes up
    task automatic send_error_tail();
        logic [7:0]  b;
        logic [15:0] v;
        case (next_tail)
            0: send_byte(8'($urandom_range(0, 31)));
            1:
            begin
                send_byte(CH_BSL);
                do
                    b = 8'($urandom_range(0, 255));
                while (is_esc_letter(b));
                send_byte(b);
            end
            2: send_bad_hex();
            3:
            begin
                send_u(pick_high());
                if ($urandom_range(0, 1))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_BSL);
                    send_byte(b);
                end
                else
                begin
                    send_byte(CH_BSL);
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_U);
                    send_byte(b);
                end
            end
            4:
            begin
                send_u(pick_high());
                do
                    v = 16'($urandom);
                while (v[15:10] == SURR_LOW);
                send_u(v);
            end
            5: send_u(pick_low());
            6:
            begin
                send_u(pick_high());
                send_bad_hex();
            end
            default: send_u(16'h0000);
        endcase
        next_tail = (next_tail + 1) % 8;
    endtask

    task automatic send_random_string();
        int nseg;
        send_byte(CH_QUOTE);
        nseg = $urandom_range(0, 5);
        repeat (nseg) send_segment();
        if ($urandom_range(0, 99) < 60)
            send_byte(CH_QUOTE);
        else
            send_error_tail();
    endtask

    // main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, one escape, highest code point, errors
        send_byte(8'h00);
        send_byte(CH_QUOTE);
        send_byte(CH_SPACE);
        send_byte(8'hff);
        send_byte(CH_BSL);
        send_byte(CH_N);
        send_u(16'hdbff);
        send_u(16'hdfff);
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
        send_byte(8'h1f);
        send_byte(CH_QUOTE);
        send_byte(CH_BSL);
        send_byte(8'h00);
        drain_results();

        // random strings with noise between them
        while (bytes_sent < ITEM_TARGET)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(CH_QUOTE + 1, 255)));
            end
            send_random_string();
            if ($urandom_range(0, 7) == 0)
                drain_results();
        end
        quiet = 1'b0;

        // wind down
        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.beat_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8.sv
sim/testbench.sv
